/* hdl/pnc_pkg.sv */
package pnc_pkg;

  localparam int unsigned NumDigits  = 5;
  localparam int unsigned GroupBars  = 5;
  localparam int unsigned ZipInW     = 17;
  localparam int unsigned ZipOutW    = 18;
  localparam int unsigned BarsW      = 27;
  localparam int unsigned InnerW     = NumDigits * GroupBars;
  localparam int unsigned QuoW       = 14;
  localparam int unsigned ProdW      = 2 * ZipInW;
  localparam int unsigned RecipShift = 20;
  localparam logic [ZipInW-1:0] RecipTen = ZipInW'(104858);
  localparam logic [3:0] ZeroSum = 4'd11;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ZipInW-1:0]  zip_in;
    logic [BarsW-1:0]   bars_in;
  } in_word_t;

  typedef struct packed {
    logic [ZipOutW-1:0] zip_out;
    logic [BarsW-1:0]   bars_out;
  } out_word_t;

  // working word carried down the digit stages
  typedef struct packed {
    kind_e              kind;
    logic [ZipInW-1:0]  zip;
    logic [BarsW-1:0]   bars;
    logic [ZipInW-1:0]  rem;
    logic [InnerW-1:0]  enc;
    logic [InnerW-1:0]  dec;
    logic [ZipOutW-1:0] acc;
  } stage_t;

  function automatic logic [GroupBars-1:0] digit_group(input logic [3:0] d);
    logic [GroupBars-1:0] g;
    case (d)
      4'd0: g = 5'b11000;
      4'd1: g = 5'b00011;
      4'd2: g = 5'b00101;
      4'd3: g = 5'b00110;
      4'd4: g = 5'b01001;
      4'd5: g = 5'b01010;
      4'd6: g = 5'b01100;
      4'd7: g = 5'b10001;
      4'd8: g = 5'b10010;
      4'd9: g = 5'b10100;
      default: g = '0;
    endcase
    return g;
  endfunction

  // bar weights 7,4,2,1,0, first bar in the top bit
  function automatic logic [3:0] group_sum(input logic [GroupBars-1:0] g);
    logic [3:0] s;
    s = (g[4] ? 4'd7 : 4'd0) + (g[3] ? 4'd4 : 4'd0) + (g[2] ? 4'd2 : 4'd0)
      + {3'b000, g[1]};
    if (s == ZeroSum) begin
      s = 4'd0;
    end
    return s;
  endfunction

endpackage

/* hdl/pnc_stage.sv */
module pnc_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pnc_pkg::stage_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pnc_pkg::stage_t out_data_o
);

  logic                            valid_q;
  pnc_pkg::stage_t                 data_q;
  pnc_pkg::stage_t                 data_d;
  logic [pnc_pkg::ProdW-1:0]       prod;
  logic [pnc_pkg::QuoW-1:0]        quo;
  logic [pnc_pkg::ZipInW-1:0]      low;
  logic [pnc_pkg::GroupBars-1:0]   dec_grp;
  logic [3:0]                      sum;
  logic [pnc_pkg::ZipOutW-1:0]     acc;

  // encode takes the lowest decimal digit, rem / 10 by reciprocal
  assign prod = pnc_pkg::ProdW'(in_data_i.rem) * pnc_pkg::ProdW'(pnc_pkg::RecipTen);
  assign quo  = prod[pnc_pkg::RecipShift +: pnc_pkg::QuoW];
  assign low  = in_data_i.rem - ({3'b000, quo} << 3) - ({3'b000, quo} << 1);

  // decode takes the leading group, zip = zip * 10 + sum
  assign dec_grp = in_data_i.dec[pnc_pkg::InnerW-1 -: pnc_pkg::GroupBars];
  assign sum     = pnc_pkg::group_sum(dec_grp);
  assign acc     = in_data_i.acc;

  always_comb begin
    data_d     = in_data_i;
    data_d.rem = {3'b000, quo};
    data_d.enc = {pnc_pkg::digit_group(low[3:0]),
                  in_data_i.enc[pnc_pkg::InnerW-1:pnc_pkg::GroupBars]};
    data_d.dec = {in_data_i.dec[pnc_pkg::InnerW-pnc_pkg::GroupBars-1:0],
                  pnc_pkg::GroupBars'(0)};
    data_d.acc = {acc[pnc_pkg::ZipOutW-4:0], 3'b000} + {acc[pnc_pkg::ZipOutW-2:0], 1'b0}
               + pnc_pkg::ZipOutW'(sum);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* hdl/postnet_zip_barcode_codec.sv */
// Five-digit POSTNET codec: each word either encodes a binary zip into the 27-bar pattern
// (frame bar, five two-of-five groups, frame bar; bit 26 is the first bar) or decodes bars
// into a zip, ignoring the frame bars, weighting group bars 7,4,2,1,0 and taking a sum of
// 11 as digit 0; malformed groups pass their raw sums. Encoding uses the low five decimal
// digits of zip_in. The datapath is five register stages, one per digit, and a new word is
// taken every cycle while the output side keeps up; each stage holds one reciprocal
// multiply for the divide by ten. Nothing needs clearing after reset.
module postnet_zip_barcode_codec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pnc_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pnc_pkg::out_word_t out_data_o
);

  logic            valid [pnc_pkg::NumDigits+1];
  logic            ready [pnc_pkg::NumDigits+1];
  pnc_pkg::stage_t data  [pnc_pkg::NumDigits+1];
  pnc_pkg::stage_t last;

  always_comb begin
    data[0].kind = in_data_i.kind;
    data[0].zip  = in_data_i.zip_in;
    data[0].bars = in_data_i.bars_in;
    data[0].rem  = in_data_i.zip_in;
    data[0].enc  = '0;
    data[0].dec  = in_data_i.bars_in[pnc_pkg::BarsW-2:1];
    data[0].acc  = '0;
  end

  assign valid[0]   = in_valid_i;
  assign in_ready_o = ready[0];

  for (genvar s = 0; s < pnc_pkg::NumDigits; s++) begin : g_stage
    pnc_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[s]),
      .in_ready_o  (ready[s]),
      .in_data_i   (data[s]),
      .out_valid_o (valid[s+1]),
      .out_ready_i (ready[s+1]),
      .out_data_o  (data[s+1])
    );
  end

  assign last                       = data[pnc_pkg::NumDigits];
  assign ready[pnc_pkg::NumDigits]  = out_ready_i;
  assign out_valid_o                = valid[pnc_pkg::NumDigits];

  always_comb begin
    if (last.kind == pnc_pkg::KIND_DECODE) begin
      out_data_o.zip_out  = last.acc;
      out_data_o.bars_out = last.bars;
    end else begin
      out_data_o.zip_out  = {1'b0, last.zip};
      out_data_o.bars_out = {1'b1, last.enc, 1'b1};
    end
  end

endmodule
